@@ rtl/multi_click_hold_detector_assert.svh @@
// Assertion macros for the multi-click hold detector.
// MCHD_ASSERT checks outside reset; MCHD_ASSERT_ALWAYS checks at every edge.
`ifndef MULTI_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define MULTI_CLICK_HOLD_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCHD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCHD_ASSERT(lbl, clk, rst, prop, msg)
`define MCHD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/mchd_pkg.sv @@
package mchd_pkg;

   localparam int NUM_BUTTONS         = 4;
   localparam int TRIGGERS_PER_BUTTON = 4;
   localparam int BTN_W               = 2;
   localparam int SLOT_W              = 2;
   localparam int CLICK_W             = 6;
   localparam int CFG_W               = 16;

   localparam logic [CLICK_W-1:0] CLICK_MAX = 6'd63;

   // configuration register indexes
   localparam logic [1:0] CSR_HOLD_TICKS  = 2'd0;
   localparam logic [1:0] CSR_IDLE_TICKS  = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_MASK = 2'd2;
   localparam logic [1:0] CSR_IN_USE      = 2'd3;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_TRIG = 1'b1;

   typedef enum logic [6:0] {
      BST_IDLE         = 7'b0000001,
      BST_PREP_PRESS   = 7'b0000010,
      BST_PRESSING     = 7'b0000100,
      BST_PREP_RELEASE = 7'b0001000,
      BST_RELEASE      = 7'b0010000,
      BST_HOLDING      = 7'b0100000,
      BST_PREP_IDLE    = 7'b1000000
   } btn_state_type;

   typedef struct packed {
      btn_state_type                  state;
      logic [CLICK_W-1:0]             clicks;
      logic                           hold;
      logic [TRIGGERS_PER_BUTTON-1:0] served;
   } btn_status_type;

   typedef struct packed {
      logic [CLICK_W-1:0] clicks;
      logic               hold;
      logic               enable;
   } trig_slot_type;

   typedef trig_slot_type [TRIGGERS_PER_BUTTON-1:0] trig_row_type;

endpackage

@@ rtl/mchd_ram.sv @@
module mchd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/mchd_step.sv @@
// One tick of one button machine, then the trigger match on the new state.
module mchd_step #(
   parameter int TICK_WIDTH = 16
) (
   input  mchd_pkg::btn_status_type         status_i,
   input  logic [TICK_WIDTH-1:0]            count_i,
   input  logic                             pressed,
   input  logic [mchd_pkg::CFG_W-1:0]       hold_ticks,
   input  logic [mchd_pkg::CFG_W-1:0]       idle_ticks,
   input  mchd_pkg::trig_row_type           row,
   output mchd_pkg::btn_status_type         status_o,
   output logic [TICK_WIDTH-1:0]            count_o,
   output logic [mchd_pkg::TRIGGERS_PER_BUTTON-1:0] fired,
   output logic                             idle_released
);

   localparam int CMP_W = (TICK_WIDTH > mchd_pkg::CFG_W) ? TICK_WIDTH : mchd_pkg::CFG_W;

   mchd_pkg::btn_status_type nxt;
   logic [TICK_WIDTH-1:0]    cnt_nxt;
   logic [TICK_WIDTH-1:0]    cnt_inc;
   logic [CMP_W-1:0]         cnt_x;
   logic                     hold_reached;
   logic                     idle_reached;

   assign cnt_x        = CMP_W'(count_i);
   assign hold_reached = cnt_x >= CMP_W'(hold_ticks);
   assign idle_reached = cnt_x >= CMP_W'(idle_ticks);
   // saturating count
   assign cnt_inc      = (&count_i) ? count_i : count_i + 1'b1;

   always_comb begin
      nxt           = status_i;
      cnt_nxt       = count_i;
      idle_released = 1'b0;
      unique case (status_i.state)
         mchd_pkg::BST_PREP_PRESS: begin
            nxt.state = mchd_pkg::BST_PRESSING;
            cnt_nxt   = '0;
         end
         mchd_pkg::BST_PRESSING: begin
            if (!pressed) begin
               nxt.state = mchd_pkg::BST_PREP_RELEASE;
            end else if (hold_reached) begin
               nxt.state = mchd_pkg::BST_HOLDING;
               cnt_nxt   = '0;
            end else begin
               cnt_nxt = cnt_inc;
            end
         end
         mchd_pkg::BST_PREP_RELEASE: begin
            cnt_nxt = '0;
            if (status_i.clicks != mchd_pkg::CLICK_MAX) begin
               nxt.clicks = status_i.clicks + 1'b1;
            end
            nxt.state = mchd_pkg::BST_RELEASE;
         end
         mchd_pkg::BST_RELEASE: begin
            if (pressed) begin
               nxt.state = mchd_pkg::BST_PREP_PRESS;
            end else if (idle_reached) begin
               nxt.state = mchd_pkg::BST_PREP_IDLE;
            end else begin
               cnt_nxt = cnt_inc;
            end
         end
         mchd_pkg::BST_HOLDING: begin
            nxt.hold = 1'b1;
            if (!pressed) begin
               cnt_nxt   = '0;
               nxt.state = mchd_pkg::BST_RELEASE;
            end
         end
         mchd_pkg::BST_PREP_IDLE: begin
            nxt.state  = mchd_pkg::BST_IDLE;
            cnt_nxt    = '0;
            nxt.clicks = '0;
            nxt.hold   = 1'b0;
         end
         default: begin
            // idle, and any stray code
            nxt.state = mchd_pkg::BST_IDLE;
            if (pressed) begin
               cnt_nxt    = '0;
               nxt.clicks = '0;
               nxt.hold   = 1'b0;
               nxt.served = '0;
               nxt.state  = mchd_pkg::BST_PREP_PRESS;
            end else begin
               idle_released = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      fired = '0;
      for (int s = 0; s < mchd_pkg::TRIGGERS_PER_BUTTON; s++) begin
         if (nxt.state != mchd_pkg::BST_IDLE && row[s].enable &&
             row[s].clicks == nxt.clicks && row[s].hold == nxt.hold && !nxt.served[s]) begin
            fired[s] = 1'b1;
         end
      end
   end

   always_comb begin
      status_o        = nxt;
      status_o.served = nxt.served | fired;
      count_o         = cnt_nxt;
   end

endmodule

@@ rtl/multi_click_hold_detector.sv @@
// Multi-click / hold gesture detector for up to four buttons. A tick beat
// (cmd 0) carries the raw level of every button; a button is pressed when its
// level equals its bit of active_level_mask. If any in-use button changed
// level, or the sticky processing flag is set, every in-use button machine
// advances one step: it counts clicks (saturating at 63), declares a hold
// after hold_ticks pressed ticks and ends the sequence after idle_ticks
// released ticks. Each button has four trigger slots that fire once per
// sequence on a click count / hold match; fired slots show up in fired_mask.
// A tick gives one result beat per button in use, in button order, with
// last_of_tick on the final one; a tick with no buttons in use gives nothing.
// A cmd 1 beat rewrites one trigger slot, re-arms it and gives no result.
// Per-button records and trigger rows live in two small synchronous RAMs,
// walked with a read-modify-write one button per cycle while the result side
// accepts beats. A tick is the accept step, then one RAM read-modify-write
// per button in use, held while the result side stalls; a trigger write is a
// row read, then the merged write back. Reset is immediate: per-row valid
// flops stand in for the reset contents of both RAMs, so there is no
// clearing pass. Configuration writes are taken every cycle (csr_ready is
// tied high) and must only be issued while the block is idle.
module multi_click_hold_detector #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [3:0]                         req_raw_levels,
   input  logic [mchd_pkg::BTN_W-1:0]         req_trig_button,
   input  logic [mchd_pkg::SLOT_W-1:0]        req_trig_slot,
   input  logic [mchd_pkg::CLICK_W-1:0]       req_trig_clicks,
   input  logic                               req_trig_hold,
   input  logic                               req_trig_enable,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mchd_pkg::BTN_W-1:0]         rsp_button_index,
   output logic [mchd_pkg::CLICK_W-1:0]       rsp_click_count,
   output logic                               rsp_is_hold,
   output logic [3:0]                         rsp_fired_mask,
   output logic                               rsp_machines_ran,
   output logic                               rsp_last_of_tick,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [mchd_pkg::CFG_W-1:0]         csr_wdata
);

`include "multi_click_hold_detector_assert.svh"

   localparam int NB    = mchd_pkg::NUM_BUTTONS;
   localparam int ST_W  = $bits(mchd_pkg::btn_status_type);
   localparam int REC_W = ST_W + TICK_WIDTH;
   localparam int ROW_W = $bits(mchd_pkg::trig_row_type);

   typedef enum logic [2:0] {
      CTL_IDLE = 3'b001,
      CTL_WALK = 3'b010,
      CTL_TRIG = 3'b100
   } ctl_state_type;

   localparam mchd_pkg::btn_status_type STATUS_RESET = '{
      state:  mchd_pkg::BST_IDLE,
      clicks: '0,
      hold:   1'b0,
      served: '0
   };

   // configuration
   logic [mchd_pkg::CFG_W-1:0] hold_ticks_ff;
   logic [mchd_pkg::CFG_W-1:0] idle_ticks_ff;
   logic [3:0]                 active_mask_ff;
   logic [2:0]                 in_use_ff;

   // control
   ctl_state_type              ctl_ff, ctl_in;
   logic [mchd_pkg::BTN_W-1:0] btn_ff, btn_in;
   logic [mchd_pkg::BTN_W-1:0] last_ff, last_in;
   logic                       run_ff, run_in;
   logic                       proc_ff, proc_in;
   logic [NB-1:0]              pressed_ff, pressed_in;
   logic [NB-1:0]              prev_level_ff, prev_level_in;
   logic [NB-1:0]              rec_valid_ff, rec_valid_in;
   logic [NB-1:0]              row_valid_ff, row_valid_in;

   // latched trigger write
   logic [mchd_pkg::BTN_W-1:0]  tbtn_ff, tbtn_in;
   logic [mchd_pkg::SLOT_W-1:0] tslot_idx_ff, tslot_idx_in;
   mchd_pkg::trig_slot_type     tslot_ff, tslot_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic [mchd_pkg::BTN_W-1:0]  out_btn_ff, out_btn_in;
   logic [mchd_pkg::CLICK_W-1:0] out_clicks_ff, out_clicks_in;
   logic                        out_hold_ff, out_hold_in;
   logic [3:0]                  out_fired_ff, out_fired_in;
   logic                        out_ran_ff, out_ran_in;
   logic                        out_last_ff, out_last_in;

   // tick setup, worked out in the accept cycle
   logic [2:0]    n_eff;
   logic [NB-1:0] use_mask;
   logic [NB-1:0] pressed_now;
   logic          changed;
   logic          req_fire;
   logic          tick_start;

   // RAM ports
   logic                        rec_we, row_we;
   logic [mchd_pkg::BTN_W-1:0]  rec_waddr;
   logic [REC_W-1:0]            rec_wdata, rec_rdata;
   logic [ROW_W-1:0]            row_wdata, row_rdata;
   logic [mchd_pkg::BTN_W-1:0]  rd_addr;

   // current record, reset values where not yet written
   logic [mchd_pkg::BTN_W-1:0]  sel_btn;
   mchd_pkg::btn_status_type    cur_status;
   logic [TICK_WIDTH-1:0]       cur_cnt;
   mchd_pkg::trig_row_type      cur_row;
   mchd_pkg::trig_row_type      new_row;
   mchd_pkg::btn_status_type    trig_status;

   // step results
   mchd_pkg::btn_status_type    step_status;
   logic [TICK_WIDTH-1:0]       step_cnt;
   logic [3:0]                  step_fired;
   logic                        step_idle_rel;

   logic can_emit;
   logic walk_go;
   logic walk_last;

   assign csr_ready = 1'b1;
   assign req_ready = (ctl_ff == CTL_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign can_emit  = !out_valid_ff || rsp_ready;
   assign walk_go   = (ctl_ff == CTL_WALK) && can_emit;
   assign walk_last = (btn_ff == last_ff);

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff  <= 16'd100;
         idle_ticks_ff  <= 16'd50;
         active_mask_ff <= '0;
         in_use_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mchd_pkg::CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata;
            mchd_pkg::CSR_IDLE_TICKS:  idle_ticks_ff  <= csr_wdata;
            mchd_pkg::CSR_ACTIVE_MASK: active_mask_ff <= csr_wdata[3:0];
            mchd_pkg::CSR_IN_USE:      in_use_ff      <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // ---------------- tick setup ----------------
   // buttons in use clamp at the button count
   assign n_eff       = (in_use_ff > 3'(NB)) ? 3'(NB) : in_use_ff;
   assign pressed_now = ~(req_raw_levels ^ active_mask_ff);

   always_comb begin
      for (int i = 0; i < NB; i++) begin
         use_mask[i] = (3'(i) < n_eff);
      end
   end

   assign changed    = |((pressed_now ^ prev_level_ff) & use_mask);
   assign tick_start = req_fire && (req_cmd == mchd_pkg::CMD_TICK) && (n_eff != 3'd0);

   // ---------------- memories ----------------
   // read address runs one button ahead of the walk; held while stalled
   always_comb begin
      unique case (ctl_ff)
         CTL_IDLE: rd_addr = (req_cmd == mchd_pkg::CMD_TRIG) ? req_trig_button : '0;
         CTL_WALK: rd_addr = walk_go ? btn_ff + 1'b1 : btn_ff;
         CTL_TRIG: rd_addr = tbtn_ff;
         default:  rd_addr = btn_ff;
      endcase
   end

   mchd_ram #(.WIDTH(REC_W), .DEPTH(NB)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rd_addr),
      .rd_data (rec_rdata)
   );

   mchd_ram #(.WIDTH(ROW_W), .DEPTH(NB)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (tbtn_ff),
      .wr_data (row_wdata),
      .rd_addr (rd_addr),
      .rd_data (row_rdata)
   );

   assign sel_btn = (ctl_ff == CTL_TRIG) ? tbtn_ff : btn_ff;

   always_comb begin
      if (rec_valid_ff[sel_btn]) begin
         cur_status = mchd_pkg::btn_status_type'(rec_rdata[REC_W-1 -: ST_W]);
         cur_cnt    = rec_rdata[TICK_WIDTH-1:0];
      end else begin
         cur_status = STATUS_RESET;
         cur_cnt    = '0;
      end
      // a row never written reads as all slots disabled
      cur_row = row_valid_ff[sel_btn] ? mchd_pkg::trig_row_type'(row_rdata) : '0;
   end

   mchd_step #(.TICK_WIDTH(TICK_WIDTH)) u_step (
      .status_i      (cur_status),
      .count_i       (cur_cnt),
      .pressed       (pressed_ff[btn_ff]),
      .hold_ticks    (hold_ticks_ff),
      .idle_ticks    (idle_ticks_ff),
      .row           (cur_row),
      .status_o      (step_status),
      .count_o       (step_cnt),
      .fired         (step_fired),
      .idle_released (step_idle_rel)
   );

   // trigger write: merge the slot, re-arm its served bit
   always_comb begin
      new_row                = cur_row;
      new_row[tslot_idx_ff]  = tslot_ff;
      trig_status            = cur_status;
      trig_status.served[tslot_idx_ff] = 1'b0;
   end

   assign row_we    = (ctl_ff == CTL_TRIG);
   assign row_wdata = ROW_W'(new_row);
   assign rec_we    = (ctl_ff == CTL_TRIG) || (walk_go && run_ff);
   assign rec_waddr = sel_btn;
   assign rec_wdata = (ctl_ff == CTL_TRIG) ? {trig_status, cur_cnt} : {step_status, step_cnt};

   // ---------------- control ----------------
   always_comb begin
      ctl_in        = ctl_ff;
      btn_in        = btn_ff;
      last_in       = last_ff;
      run_in        = run_ff;
      proc_in       = proc_ff;
      pressed_in    = pressed_ff;
      prev_level_in = prev_level_ff;
      rec_valid_in  = rec_valid_ff;
      row_valid_in  = row_valid_ff;
      tbtn_in       = tbtn_ff;
      tslot_idx_in  = tslot_idx_ff;
      tslot_in      = tslot_ff;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_fire && req_cmd == mchd_pkg::CMD_TRIG) begin
               tbtn_in         = req_trig_button;
               tslot_idx_in    = req_trig_slot;
               tslot_in.clicks = req_trig_clicks;
               tslot_in.hold   = req_trig_hold;
               tslot_in.enable = req_trig_enable;
               ctl_in          = CTL_TRIG;
            end else if (tick_start) begin
               pressed_in    = pressed_now;
               prev_level_in = (prev_level_ff & ~use_mask) | (pressed_now & use_mask);
               run_in        = changed || proc_ff;
               if (changed || proc_ff) begin
                  proc_in = 1'b1;
               end
               btn_in  = '0;
               last_in = mchd_pkg::BTN_W'(n_eff - 3'd1);
               ctl_in  = CTL_WALK;
            end
         end
         CTL_WALK: begin
            if (walk_go) begin
               if (run_ff) begin
                  rec_valid_in[btn_ff] = 1'b1;
                  if (step_idle_rel) begin
                     proc_in = 1'b0;
                  end
               end
               if (walk_last) begin
                  ctl_in = CTL_IDLE;
               end else begin
                  btn_in = btn_ff + 1'b1;
               end
            end
         end
         CTL_TRIG: begin
            rec_valid_in[tbtn_ff] = 1'b1;
            row_valid_in[tbtn_ff] = 1'b1;
            ctl_in                = CTL_IDLE;
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   // ---------------- result register ----------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_btn_in    = out_btn_ff;
      out_clicks_in = out_clicks_ff;
      out_hold_in   = out_hold_ff;
      out_fired_in  = out_fired_ff;
      out_ran_in    = out_ran_ff;
      out_last_in   = out_last_ff;
      if (walk_go) begin
         out_valid_in = 1'b1;
         out_btn_in   = btn_ff;
         out_ran_in   = run_ff;
         out_last_in  = walk_last;
         if (run_ff) begin
            out_clicks_in = step_status.clicks;
            out_hold_in   = step_status.hold;
            out_fired_in  = step_fired;
         end else begin
            out_clicks_in = cur_status.clicks;
            out_hold_in   = cur_status.hold;
            out_fired_in  = '0;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= CTL_IDLE;
         btn_ff        <= '0;
         last_ff       <= '0;
         run_ff        <= 1'b0;
         proc_ff       <= 1'b0;
         prev_level_ff <= '0;
         rec_valid_ff  <= '0;
         row_valid_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         ctl_ff        <= ctl_in;
         btn_ff        <= btn_in;
         last_ff       <= last_in;
         run_ff        <= run_in;
         proc_ff       <= proc_in;
         prev_level_ff <= prev_level_in;
         rec_valid_ff  <= rec_valid_in;
         row_valid_ff  <= row_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pressed_ff    <= pressed_in;
      tbtn_ff       <= tbtn_in;
      tslot_idx_ff  <= tslot_idx_in;
      tslot_ff      <= tslot_in;
      out_btn_ff    <= out_btn_in;
      out_clicks_ff <= out_clicks_in;
      out_hold_ff   <= out_hold_in;
      out_fired_ff  <= out_fired_in;
      out_ran_ff    <= out_ran_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_button_index = out_btn_ff;
   assign rsp_click_count  = out_clicks_ff;
   assign rsp_is_hold      = out_hold_ff;
   assign rsp_fired_mask   = out_fired_ff;
   assign rsp_machines_ran = out_ran_ff;
   assign rsp_last_of_tick = out_last_ff;

   // ---------------- checks ----------------
   `MCHD_ASSERT(a_fired_needs_run, clock, reset,
      (rsp_valid && rsp_fired_mask != 4'd0) |-> rsp_machines_ran, "fired slots without a machine step")
   `MCHD_ASSERT(a_walk_in_range, clock, reset,
      (ctl_ff == CTL_WALK) |-> (btn_ff <= last_ff), "walk index past last button in use")
   `MCHD_ASSERT(a_trig_one_cycle, clock, reset,
      (ctl_ff == CTL_TRIG) |=> (ctl_ff == CTL_IDLE), "trigger write did not finish in one cycle")
   `MCHD_ASSERT(a_rec_write_owner, clock, reset,
      rec_we |-> (ctl_ff == CTL_TRIG || (ctl_ff == CTL_WALK && run_ff)), "stray record write")

endmodule
